// File: hw/rtl/swt_pkg.sv
// Shared types and constants for the square-wave tone generator.
// Used by swt_div, swt_datapath, swt_ctrl and the top level.
package swt_pkg;

  // Opcodes carried in the input tuser field
  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_START = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;

  // Carrier rate and toggle budget limits
  localparam int          CARRIER_W     = 22;
  localparam logic [31:0] CARRIER_HZ    = 32'd4000000;
  localparam logic [31:0] COUNT_CAP     = 32'hffff_fffe;
  localparam logic [31:0] COUNT_FOREVER = 32'hffff_ffff;
  localparam logic [31:0] MS_PER_S      = 32'd1000;

  // Datapath widths: effective frequency is at most 2 MHz
  localparam int FE_W       = 21;
  localparam int DUR_W      = 32;
  localparam int DQ_W       = 23;   // duration / 1000
  localparam int DR_W       = 10;   // duration % 1000
  localparam int FRAC_W     = 32;   // 2 * fe * (duration % 1000)
  localparam int WHOLE_W    = 45;   // 2 * fe * (duration / 1000)
  localparam int DIVIDEND_W = CARRIER_W;
  localparam int DIVISOR_W  = 32;
  localparam int DIV_CNT_W  = $clog2(DIVIDEND_W);

  // Divide by 1000: multiply by ceil(2^38 / 1000), keep bits 38 and up.
  // Exact for every 32-bit operand.
  localparam int              MS_RECIP_W  = 29;
  localparam logic [28:0]     MS_RECIP    = 29'h10624dd3;
  localparam int              MS_SHIFT    = 38;
  localparam int              SCALED_W    = DUR_W + MS_RECIP_W;
  localparam logic [DR_W-1:0] MS_PER_S_LO = DR_W'(MS_PER_S);

  // Operand selection for the shared divider
  typedef enum logic {
    DIV_FREQ,   // carrier / frequency
    DIV_FE      // carrier / (2 * half period)
  } div_sel_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_F,
    ST_GO_E,
    ST_DIV_E,
    ST_MUL,
    ST_FRAC,
    ST_SUM,
    ST_LOAD
  } ctl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     tick;
    logic     stop;
    logic     capture;
    logic     div_start;
    div_sel_t div_sel;
    logic     set_half;
    logic     set_fe;
    logic     split_q;    // duration / 1000
    logic     split_r;    // duration % 1000
    logic     mul;
    logic     frac_q;
    logic     set_cnt;
    logic     load;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic freq_zero;
    logic div_done;
  } dp_sts_t;

endpackage

// File: hw/rtl/swt_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on swt_pkg for operand widths.
module swt_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [swt_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [swt_pkg::DIVISOR_W-1:0]    divisor,
  output logic [swt_pkg::DIVIDEND_W-1:0]   quotient,
  output logic                             done
);
  import swt_pkg::*;

  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVIDEND_W-1:0] quo_r, quo_nxt;
  logic [DIVISOR_W-1:0]  dsr_r, dsr_nxt;
  logic [DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    diff;

  // One shift-subtract step
  assign rem_sh = {rem_r, quo_r[DIVIDEND_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = DIV_CNT_W'(DIVIDEND_W - 1);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!diff[DIVISOR_W]) begin
        rem_nxt = diff[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[DIVISOR_W-1:0];
        quo_nxt = {quo_r[DIVIDEND_W-2:0], 1'b0};
      end
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign quotient = quo_r;
  assign done     = done_r;

endmodule

// File: hw/rtl/swt_datapath.sv
// Tone state, period counter and start-time arithmetic.
// Depends on swt_pkg and instantiates swt_div.
module swt_datapath #(
  parameter int PERIOD_LIMIT = 65536
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  swt_pkg::ctl_cmd_t        cmd,
  output swt_pkg::dp_sts_t         sts,
  input  logic [31:0]              frequency,
  input  logic [31:0]              duration_ms,
  output logic                     level,
  output logic                     running
);
  import swt_pkg::*;

  localparam int PW = $clog2(PERIOD_LIMIT);
  localparam int HW = $clog2(PERIOD_LIMIT + 1);

  // Architectural tone state
  logic              running_r, running_nxt;
  logic              level_r, level_nxt;
  logic [PW-1:0]     phase_r, phase_nxt;
  logic [HW-1:0]     half_r, half_nxt;
  logic [31:0]       toggles_r, toggles_nxt;

  // Start-time work registers
  logic [DUR_W-1:0]   dur_r;
  logic [HW-1:0]      half_calc_r;
  logic [FE_W-1:0]    fe_r;
  logic [DQ_W-1:0]    dur_q_r;
  logic [DR_W-1:0]    dur_rem_r;
  logic [WHOLE_W-1:0] whole_r;
  logic [FRAC_W-1:0]  frac_r;
  logic [DQ_W-1:0]    frac_q_r;
  logic [31:0]        cnt_r;

  logic [DIVIDEND_W-1:0] div_dividend;
  logic [DIVISOR_W-1:0]  div_divisor;
  logic [DIVIDEND_W-1:0] div_quo;
  logic                  div_done;
  logic [CARRIER_W-2:0]  half_raw;
  logic [HW-1:0]         half_clamped;
  logic [HW-1:0]         phase_inc;
  logic [FE_W:0]         fe2;
  logic [SCALED_W-1:0]   dur_scaled;
  logic [SCALED_W-1:0]   frac_scaled;
  logic [WHOLE_W-1:0]    budget;

  // Divider operand select; the dividend is always the carrier rate
  assign div_dividend = DIVIDEND_W'(CARRIER_HZ);
  always_comb begin
    unique case (cmd.div_sel)
      DIV_FREQ: div_divisor = frequency;
      DIV_FE:   div_divisor = DIVISOR_W'({half_calc_r, 1'b0});
    endcase
  end

  swt_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  // Half period = quotient / 2, clamped to [1, PERIOD_LIMIT]
  assign half_raw = div_quo[CARRIER_W-1:1];
  always_comb begin
    if (half_raw == '0) begin
      half_clamped = HW'(1);
    end else if (half_raw > (CARRIER_W-1)'(PERIOD_LIMIT)) begin
      half_clamped = HW'(PERIOD_LIMIT);
    end else begin
      half_clamped = half_raw[HW-1:0];
    end
  end

  // Budget = 2*fe*(dur/1000) + (2*fe*(dur%1000))/1000, both divides by reciprocal
  assign fe2         = {fe_r, 1'b0};
  assign dur_scaled  = SCALED_W'(dur_r) * SCALED_W'(MS_RECIP);
  assign frac_scaled = SCALED_W'(frac_r) * SCALED_W'(MS_RECIP);
  assign budget      = whole_r + WHOLE_W'(frac_q_r);

  // Start-time work registers
  always_ff @(posedge clk) begin
    if (cmd.capture)  dur_r <= duration_ms;
    if (cmd.set_half) half_calc_r <= half_clamped;
    if (cmd.set_fe)   fe_r <= div_quo[FE_W-1:0];
    if (cmd.split_q)  dur_q_r <= dur_scaled[SCALED_W-1:MS_SHIFT];
    // remainder is below 1000, so the low bits alone give it
    if (cmd.split_r)  dur_rem_r <= dur_r[DR_W-1:0] - DR_W'(dur_q_r[DR_W-1:0] * MS_PER_S_LO);
    if (cmd.mul) begin
      whole_r <= WHOLE_W'(fe2) * WHOLE_W'(dur_q_r);
      frac_r  <= FRAC_W'(fe2) * FRAC_W'(dur_rem_r);
    end
    if (cmd.frac_q)   frac_q_r <= frac_scaled[SCALED_W-1:MS_SHIFT];
    if (cmd.set_cnt) begin
      if (budget > WHOLE_W'(COUNT_CAP)) cnt_r <= COUNT_CAP;
      else                              cnt_r <= budget[31:0];
    end
  end

  assign phase_inc = HW'(phase_r) + 1'b1;

  // Tone state update: tick, stop, or start load
  always_comb begin
    running_nxt = running_r;
    level_nxt   = level_r;
    phase_nxt   = phase_r;
    half_nxt    = half_r;
    toggles_nxt = toggles_r;
    priority if (cmd.load) begin
      running_nxt = 1'b1;
      phase_nxt   = '0;
      half_nxt    = half_calc_r;
      toggles_nxt = (dur_r == '0) ? COUNT_FOREVER : cnt_r;
    end else if (cmd.stop) begin
      running_nxt = 1'b0;
      level_nxt   = 1'b0;
      phase_nxt   = '0;
    end else if (cmd.tick && running_r) begin
      if (phase_inc < half_r) begin
        phase_nxt = phase_inc[PW-1:0];
      end else begin
        // period event
        phase_nxt = '0;
        if (toggles_r != '0) begin
          level_nxt = ~level_r;
          if (toggles_r != COUNT_FOREVER) toggles_nxt = toggles_r - 1'b1;
        end else begin
          running_nxt = 1'b0;
          level_nxt   = 1'b0;
        end
      end
    end else begin
      running_nxt = running_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      level_r   <= 1'b0;
      phase_r   <= '0;
      half_r    <= HW'(1);
      toggles_r <= '0;
    end else begin
      running_r <= running_nxt;
      level_r   <= level_nxt;
      phase_r   <= phase_nxt;
      half_r    <= half_nxt;
      toggles_r <= toggles_nxt;
    end
  end

  assign sts.freq_zero = (frequency == '0);
  assign sts.div_done  = div_done;
  assign level         = level_r;
  assign running       = running_r;

endmodule

// File: hw/rtl/swt_ctrl.sv
// Controller: stream handshakes and the start-command sequence.
// Depends on swt_pkg; drives the command struct of swt_datapath.
module swt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [1:0]         opcode,
  output logic               out_tvalid,
  input  logic               out_tready,
  output swt_pkg::ctl_cmd_t  cmd,
  input  swt_pkg::dp_sts_t   sts
);
  import swt_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       accept;
  logic       start_go;
  logic       slot_free;
  logic       produce;

  assign slot_free = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign start_go  = (opcode == OP_START) && !sts.freq_zero;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (accept && start_go) state_nxt = ST_DIV_F;
      ST_DIV_F: if (sts.div_done) state_nxt = ST_GO_E;
      ST_GO_E:  state_nxt = ST_DIV_E;
      ST_DIV_E: if (sts.div_done) state_nxt = ST_MUL;
      ST_MUL:   state_nxt = ST_FRAC;
      ST_FRAC:  state_nxt = ST_SUM;
      ST_SUM:   state_nxt = ST_LOAD;
      ST_LOAD:  if (slot_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and datapath commands
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    produce   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = slot_free;
        if (accept) begin
          if (start_go) begin
            cmd.capture   = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_FREQ;
          end else begin
            cmd.tick = (opcode == OP_TICK);
            cmd.stop = (opcode == OP_STOP);
            produce  = 1'b1;
          end
        end
      end
      ST_DIV_F: cmd.set_half = sts.div_done;
      ST_GO_E: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = DIV_FE;
        cmd.split_q   = 1'b1;
      end
      ST_DIV_E: begin
        cmd.div_sel = DIV_FE;
        cmd.set_fe  = sts.div_done;
        cmd.split_r = sts.div_done;
      end
      ST_MUL:   cmd.mul = 1'b1;
      ST_FRAC:  cmd.frac_q = 1'b1;
      ST_SUM:   cmd.set_cnt = 1'b1;
      ST_LOAD: begin
        cmd.load = slot_free;
        produce  = slot_free;
      end
      default: cmd = '0;
    endcase
  end

  assign out_valid_nxt = produce ? 1'b1 : (out_valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // Every non-computing transaction yields a result on the next cycle
  a_direct_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !start_go) |=> out_tvalid)
    else $error("missing result after tick/stop transaction");

  // A start result follows the load of the new tone state
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD && slot_free) |=> (out_tvalid && state_r == ST_IDLE))
    else $error("start load did not present a result");

  // A divider launch is always followed by a wait state
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> (state_r == ST_DIV_F || state_r == ST_DIV_E))
    else $error("divider launched outside the start sequence");

  // Divider completes only while the controller waits for it
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == ST_DIV_F || state_r == ST_DIV_E))
    else $error("unexpected divider completion");

endmodule

// File: hw/rtl/square_wave_tone_generator.sv
// Square-wave tone generator with a 4 MHz carrier tick input. A carrier
// tick, a stop, an unused opcode or a start with zero frequency is answered
// in the cycle after it is accepted, so ticks stream at one per cycle while
// results are taken. A start with nonzero frequency presents its result, and
// can be followed by the next transaction, only after its whole sequence:
// the half period and the effective frequency each take one pass through the
// shared bit-serial divider (22 steps plus launch and completion), then the
// states ST_MUL, ST_FRAC and ST_SUM form the toggle budget by multiplying
// with a scaled reciprocal of 1000, and ST_LOAD loads the new tone state once
// the output slot is free. Each input transaction yields exactly one output
// transaction carrying the tone level and the playing flag after that item; a
// result that is not yet taken holds off the next input transaction, and a
// result and the next input can be exchanged in the same cycle.
module square_wave_tone_generator #(
  parameter int PERIOD_LIMIT = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] frequency, [63:32] duration_ms
  input  logic [1:0]  in_tuser,   // [1:0] opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [0] tone_out, [1] active, [7:2] zero
);
  import swt_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;
  logic     level;
  logic     running;

  swt_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .opcode     (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  swt_datapath #(
    .PERIOD_LIMIT (PERIOD_LIMIT)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .frequency   (in_tdata[31:0]),
    .duration_ms (in_tdata[63:32]),
    .level       (level),
    .running     (running)
  );

  assign out_tdata = {6'b0, running, level};

endmodule

// File: tb/tb_square_wave_tone_generator.sv
// Self-checking testbench for the square-wave tone generator.
// Drives opcode/frequency/duration transactions, predicts level and playing flag
// per transaction, and checks every result. Depends on swt_pkg and the top level only.
`timescale 1ns / 1ps

module tb_square_wave_tone_generator;
  import swt_pkg::*;

  localparam int          PERIOD_LIMIT   = 65536;
  localparam logic [1:0]  OP_UNUSED      = 2'd3;
  localparam int          RANDOM_ITEMS   = 905;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          MAX_REPORTS    = 30;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] freq;
    logic [31:0] dur_ms;
    bit          drain;   // hold off until all results are back
  } tone_cmd_t;

  typedef struct {
    logic level;
    logic active;
  } tone_state_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // [31:0] frequency, [63:32] duration_ms
  logic [1:0]  in_tuser = '0;   // [1:0] opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [0] tone_out, [1] active, [7:2] zero

  tone_cmd_t   cmd_queue[$];
  tone_state_t expected_levels[$];

  // Predicted tone state
  logic        tone_running = 1'b0;
  logic        tone_level = 1'b0;
  logic [15:0] tone_phase = '0;
  logic [16:0] tone_half = 17'd1;
  logic [31:0] toggles_left = '0;

  // Bookkeeping
  int items_total = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int send_wait = 0;
  int take_wait = 0;
  bit send_burst = 1'b0;
  bit take_burst = 1'b0;
  int n_ticks = 0;
  int n_starts = 0;
  int n_zero_freq = 0;
  int n_stops = 0;
  int n_unused = 0;
  int n_toggles = 0;
  int n_runouts = 0;

  square_wave_tone_generator #(
    .PERIOD_LIMIT(PERIOD_LIMIT)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #10 clk = ~clk;

  // Tone state after one transaction
  function automatic tone_state_t advance_tone(input logic [1:0] op, input logic [31:0] freq,
                                               input logic [31:0] dur_ms);
    logic [31:0] half32;
    logic [31:0] fe;
    logic [63:0] budget;
    tone_state_t r;
    case (op)
      OP_TICK: begin
        n_ticks++;
        if (tone_running) begin
          if (32'(tone_phase) + 32'd1 < 32'(tone_half)) begin
            tone_phase = tone_phase + 16'd1;
          end else begin
            tone_phase = '0;
            if (toggles_left != 32'd0) begin
              tone_level = ~tone_level;
              n_toggles++;
              if (toggles_left != COUNT_FOREVER) toggles_left = toggles_left - 32'd1;
            end else begin
              // budget used up: tone ends on this period event
              tone_running = 1'b0;
              tone_level = 1'b0;
              n_runouts++;
            end
          end
        end
      end
      OP_START: begin
        n_starts++;
        if (freq == 32'd0) begin
          n_zero_freq++;
        end else begin
          half32 = (CARRIER_HZ / freq) / 32'd2;
          if (half32 < 32'd1) half32 = 32'd1;
          if (half32 > 32'(PERIOD_LIMIT)) half32 = 32'(PERIOD_LIMIT);
          tone_half = half32[16:0];
          if (dur_ms == 32'd0) begin
            toggles_left = COUNT_FOREVER;
          end else begin
            fe = CARRIER_HZ / (32'd2 * half32);
            budget = (64'(fe) * 64'(dur_ms) * 64'd2) / 64'(MS_PER_S);
            toggles_left = (budget > 64'(COUNT_CAP)) ? COUNT_CAP : budget[31:0];
          end
          // level is kept across a restart
          tone_running = 1'b1;
          tone_phase = '0;
        end
      end
      OP_STOP: begin
        n_stops++;
        tone_running = 1'b0;
        tone_level = 1'b0;
        tone_phase = '0;
      end
      default: n_unused++;
    endcase
    r.level = tone_level;
    r.active = tone_running;
    return r;
  endfunction

  task automatic queue_item(input logic [1:0] op, input logic [31:0] freq,
                            input logic [31:0] dur_ms, input bit drain = 1'b0);
    tone_cmd_t c;
    c.op = op;
    c.freq = freq;
    c.dur_ms = dur_ms;
    c.drain = drain;
    cmd_queue.push_back(c);
  endtask

  // Tick transactions carry random payload, which the block ignores
  task automatic queue_ticks(input int count);
    repeat (count) queue_item(OP_TICK, $urandom, $urandom);
  endtask

  // Driver: presents queued transactions with random gaps
  always @(posedge clk) begin
    tone_cmd_t item;
    if (rst_n) begin
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain &&
                       (expected_levels.size() != 0 || (in_tvalid && in_tready)))) begin
          item = cmd_queue.pop_front();
          in_tuser <= item.op;
          in_tdata <= {item.dur_ms, item.freq};
          in_tvalid <= 1'b1;
          if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
          send_wait = send_burst ? 0 : $urandom_range(0, 6);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predicts on input transactions, checks output transactions
  always @(posedge clk) begin
    tone_state_t exp_state;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_levels.push_back(advance_tone(in_tuser, in_tdata[31:0], in_tdata[63:32]));
        items_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_levels.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: unexpected result, actual level %b active %b",
                     $time, out_tdata[0], out_tdata[1]);
        end else begin
          exp_state = expected_levels.pop_front();
          if (out_tdata[0] !== exp_state.level) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: tone_out mismatch, expected %b actual %b",
                       $time, exp_state.level, out_tdata[0]);
          end
          if (out_tdata[1] !== exp_state.active) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: active mismatch, expected %b actual %b",
                       $time, exp_state.active, out_tdata[1]);
          end
        end
        results_checked++;
        if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
        take_wait = take_burst ? 0 : $urandom_range(0, 6);
      end else if (take_wait > 0) begin
        take_wait--;
      end
      out_tready <= (take_wait == 0);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Watchdog on stalled handshakes
  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int directed_count;
    int seq_kind;
    logic [31:0] f;
    logic [31:0] d;

    // Idle-state corners
    queue_item(OP_TICK, 32'd0, 32'd0);
    queue_item(OP_STOP, 32'hffff_ffff, 32'hffff_ffff);
    queue_item(OP_UNUSED, 32'd0, 32'd0);
    queue_item(OP_START, 32'd0, 32'd5);
    queue_ticks(1);
    // Forever tone at the shortest half period, then ignored items while playing
    queue_item(OP_START, 32'd2000000, 32'd0);
    queue_ticks(4);
    queue_item(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff);
    queue_item(OP_START, 32'd0, 32'd1);
    queue_ticks(1);
    // Restart while playing keeps the level; then stop and tick while idle
    queue_item(OP_START, 32'd1000000, 32'd3);
    queue_ticks(5);
    queue_item(OP_STOP, 32'd0, 32'd0);
    queue_ticks(1);
    // Lowest frequency clamps the half period; longest duration
    queue_item(OP_START, 32'd1, 32'hffff_ffff);
    queue_ticks(3);
    queue_item(OP_STOP, 32'd0, 32'd0);
    // Highest frequency with the budget capped
    queue_item(OP_START, 32'hffff_ffff, 32'hffff_ffff);
    queue_ticks(3);
    queue_item(OP_START, CARRIER_HZ, 32'd1);
    queue_ticks(2);
    queue_item(OP_STOP, 32'd0, 32'd0);
    // Zero budget: active without toggling; sent after a full drain
    queue_item(OP_START, 32'd499, 32'd1, 1'b1);
    queue_ticks(5);
    queue_item(OP_STOP, 32'd0, 32'd0);
    directed_count = cmd_queue.size();

    // Random part: mostly start-and-tick sequences, some noise
    while (cmd_queue.size() < directed_count + RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) < 7) begin
        seq_kind = $urandom_range(0, 19);
        if (seq_kind < 8) f = $urandom_range(32'd2000000, 32'hffff_ffff);
        else if (seq_kind < 14) f = $urandom_range(32'd100000, 32'd2000000);
        else if (seq_kind < 17) f = $urandom;
        else f = $urandom_range(32'd1, 32'd1000);
        seq_kind = $urandom_range(0, 19);
        if (seq_kind < 5) d = 32'd0;
        else if (seq_kind < 15) d = $urandom_range(1, 100);
        else if (seq_kind < 18) d = $urandom;
        else d = 32'hffff_ffff;
        queue_item(OP_START, f, d);
        queue_ticks($urandom_range(1, 40));
        if ($urandom_range(0, 3) == 0) queue_item(OP_STOP, $urandom, $urandom);
      end else begin
        case ($urandom_range(0, 4))
          0: queue_ticks(1);
          1: queue_item(OP_STOP, $urandom, $urandom);
          2: queue_item(OP_UNUSED, $urandom, $urandom);
          3: queue_item(OP_START, 32'd0, $urandom);
          default: queue_item(OP_START, $urandom, $urandom);
        endcase
      end
    end
    items_total = cmd_queue.size();

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (items_accepted < items_total || expected_levels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_levels.size() != 0) begin
      mismatches++;
      $display("%0t: %0d results never arrived", $time, expected_levels.size());
    end

    $display("Covered %0d transactions: %0d ticks, %0d starts (%0d zero frequency),",
             items_accepted, n_ticks, n_starts, n_zero_freq);
    $display("%0d stops, %0d unused opcodes; %0d toggles, %0d run-outs, %0d results checked.",
             n_stops, n_unused, n_toggles, n_runouts, results_checked);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
